@@ sv/twri_pkg.sv @@
// Shared types and constants for the time window route insertion block.
package twri_pkg;

    localparam int TIME_W      = 32;
    localparam int LOC_W       = 6;
    localparam int JOB_W       = 6;
    localparam int POS_W       = 7;
    localparam int SLOT_W      = 2;
    localparam int CNT_W       = 3;
    localparam int RIDX_W      = 6;
    localparam int ROUTE_DEPTH = 64;
    localparam int MAX_WIN     = 4;
    localparam int CFG_IDX_W   = 3;

    localparam logic [2:0] F_TRAVEL = 3'd0;
    localparam logic [2:0] F_JOB    = 3'd1;
    localparam logic [2:0] F_WIN    = 3'd2;
    localparam logic [2:0] F_CHECK  = 3'd3;
    localparam logic [2:0] F_ADD    = 3'd4;

    localparam logic [1:0] S_OK     = 2'd0;
    localparam logic [1:0] S_INFEAS = 2'd1;
    localparam logic [1:0] S_FULL   = 2'd2;
    localparam logic [1:0] S_BADPOS = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_VSTART  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VEND    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HAS_SD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SD_LOC  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HAS_ED  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ED_LOC  = 3'd5;

    typedef struct packed {
        logic [SLOT_W-1:0] win;
        logic [TIME_W-1:0] lat;
        logic [TIME_W-1:0] ear;
        logic [JOB_W-1:0]  job;
    } t_rte;

    typedef struct packed {
        logic [CNT_W-1:0]  cnt;
        logic [TIME_W-1:0] svc;
        logic [LOC_W-1:0]  loc;
    } t_job;

    typedef struct packed {
        logic [TIME_W-1:0] close;
        logic [TIME_W-1:0] open;
    } t_win;

endpackage

@@ sv/time_window_route_insertion.sv @@
// Route insertion engine with time windows, built around block memories.
//
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tuser: func; tdata: job and load fields
// m_*       out  m_tvalid/m_tready  tdata: status, feasible, length, window, times
// i_cfg_*   in   i_cfg_we           i_cfg_idx selects register, i_cfg_data value
//
// Load words and early rejects go from idle straight to the result state. A check
// runs a chain of dependent memory reads plus the window scan. An add also runs
// the entry shift and the forward and backward propagation walks, and each of
// these touches one route entry per cycle.
// Reset is synchronous and active low and clears control and configuration only.
// A word is taken only while the engine is idle; a finished result waits in the
// output register and the next word is taken while it waits.
module time_window_route_insertion
    import twri_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [TIME_W-1:0]    i_cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // job_id, position, from_loc, to_loc, travel_time, job_loc, service_time,
    // window_count, window_slot, window_open, window_close, zero pad
    input  logic [167:0]         s_tdata,
    // func
    input  logic [2:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // status, feasible, route_length, chosen_window, start_earliest,
    // start_latest, zero pad
    output logic [79:0]          m_tdata
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_J1    = 4'd1;
    localparam logic [3:0] ST_J2    = 4'd2;
    localparam logic [3:0] ST_J3    = 4'd3;
    localparam logic [3:0] ST_J4    = 4'd4;
    localparam logic [3:0] ST_SCAN  = 4'd5;
    localparam logic [3:0] ST_MARG  = 4'd6;
    localparam logic [3:0] ST_ADJ   = 4'd7;
    localparam logic [3:0] ST_SHIFT = 4'd8;
    localparam logic [3:0] ST_INS   = 4'd9;
    localparam logic [3:0] ST_WALK  = 4'd10;
    localparam logic [3:0] ST_DONE  = 4'd11;

    localparam logic [32:0] TIME_SAT = 33'h1_0000_0000;

    // Input fields
    logic [JOB_W-1:0]  in_job;
    logic [POS_W-1:0]  in_pos;
    logic [LOC_W-1:0]  in_from, in_to, in_jloc;
    logic [TIME_W-1:0] in_travel, in_svc, in_open, in_close;
    logic [CNT_W-1:0]  in_wcnt;
    logic [SLOT_W-1:0] in_slot;

    assign in_job    = s_tdata[5:0];
    assign in_pos    = s_tdata[12:6];
    assign in_from   = s_tdata[18:13];
    assign in_to     = s_tdata[24:19];
    assign in_travel = s_tdata[56:25];
    assign in_jloc   = s_tdata[62:57];
    assign in_svc    = s_tdata[94:63];
    assign in_wcnt   = s_tdata[97:95];
    assign in_slot   = s_tdata[99:98];
    assign in_open   = s_tdata[131:100];
    assign in_close  = s_tdata[163:132];

    // Memories
    logic [TIME_W-1:0] mem_trv [0:4095];
    t_job              mem_job [0:63];
    t_win              mem_win [0:255];
    t_rte              mem_rte [0:ROUTE_DEPTH-1];

    logic [2*LOC_W-1:0]      trv_ra, trv_wa;
    logic [TIME_W-1:0]       trv_wd;
    logic                    trv_we;
    logic [JOB_W-1:0]        job_ra, job_wa;
    t_job                    job_wd;
    logic                    job_we;
    logic [JOB_W+SLOT_W-1:0] win_ra, win_wa;
    t_win                    win_wd;
    logic                    win_we;
    logic [RIDX_W-1:0]       rte_ra, rte_wa;
    t_rte                    rte_wd;
    logic                    rte_we;

    logic [TIME_W-1:0] r_trv_q;
    t_job              r_job_q;
    t_win              r_win_q;
    t_rte              r_rte_q;

    always_ff @(posedge i_clk) begin
        if (trv_we) begin
            mem_trv[trv_wa] <= trv_wd;
        end
        r_trv_q <= mem_trv[trv_ra];
    end

    always_ff @(posedge i_clk) begin
        if (job_we) begin
            mem_job[job_wa] <= job_wd;
        end
        r_job_q <= mem_job[job_ra];
    end

    always_ff @(posedge i_clk) begin
        if (win_we) begin
            mem_win[win_wa] <= win_wd;
        end
        r_win_q <= mem_win[win_ra];
    end

    always_ff @(posedge i_clk) begin
        if (rte_we) begin
            mem_rte[rte_wa] <= rte_wd;
        end
        r_rte_q <= mem_rte[rte_ra];
    end

    // Configuration registers
    logic [TIME_W-1:0] r_vst, r_vet;
    logic              r_hs, r_he;
    logic [LOC_W-1:0]  r_sdl, r_edl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vst <= '0;
            r_vet <= '1;
            r_hs  <= 1'b0;
            r_sdl <= '0;
            r_he  <= 1'b0;
            r_edl <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_VSTART: r_vst <= i_cfg_data;
                CFG_VEND:   r_vet <= i_cfg_data;
                CFG_HAS_SD: r_hs  <= i_cfg_data[0];
                CFG_SD_LOC: r_sdl <= i_cfg_data[LOC_W-1:0];
                CFG_HAS_ED: r_he  <= i_cfg_data[0];
                CFG_ED_LOC: r_edl <= i_cfg_data[LOC_W-1:0];
                default: ;
            endcase
        end
    end

    // Engine registers
    logic [3:0]        r_state, n_state;
    logic              r_m_valid, n_m_valid;
    logic [79:0]       r_m_data, n_m_data;
    logic [POS_W-1:0]  r_count, n_count;
    logic [2:0]        r_func, n_func;
    logic [JOB_W-1:0]  r_job, n_job;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [LOC_W-1:0]  r_oloc, n_oloc;
    logic [TIME_W-1:0] r_osvc, n_osvc;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [TIME_W-1:0] r_pear, n_pear;
    logic [TIME_W-1:0] r_psvc, n_psvc;
    logic [TIME_W-1:0] r_slat, n_slat;
    logic [TIME_W-1:0] r_lclose, n_lclose;
    logic [33:0]       r_e, n_e;
    logic [TIME_W-1:0] r_l, n_l;
    logic [SLOT_W-1:0] r_w, n_w;
    logic [SLOT_W-1:0] r_first, n_first;
    logic [SLOT_W-1:0] r_best, n_best;
    logic [TIME_W-1:0] r_marg, n_marg;
    logic [TIME_W-1:0] r_bo, n_bo;
    logic [TIME_W-1:0] r_bc, n_bc;
    logic [RIDX_W-1:0] r_i, n_i;
    logic              r_dir, n_dir;
    logic [RIDX_W-1:0] r_k, n_k;
    logic [POS_W-1:0]  r_left, n_left;
    logic [32:0]       r_chain, n_chain;
    logic [LOC_W-1:0]  r_prev_loc, n_prev_loc;
    logic [TIME_W-1:0] r_prev_svc, n_prev_svc;
    logic              r_v1, n_v1, r_v2, n_v2, r_v3, n_v3;
    logic [RIDX_W-1:0] r_idx1, n_idx1, r_idx2, n_idx2, r_idx3, n_idx3;
    t_rte              r_ent2, n_ent2, r_ent3, n_ent3;
    logic [TIME_W-1:0] r_svc3, n_svc3;
    logic [1:0]        r_res_status, n_res_status;
    logic              r_res_feas, n_res_feas;
    logic [SLOT_W-1:0] r_res_ch, n_res_ch;
    logic [TIME_W-1:0] r_res_e, n_res_e;
    logic [TIME_W-1:0] r_res_l, n_res_l;

    // Datapath terms
    logic [CNT_W-1:0]  cnt_c, cnt_m1;
    logic [33:0]       e_calc;
    logic              at_end;
    logic [TIME_W-1:0] nt, nl;
    logic [34:0]       need, l_calc;
    logic [TIME_W-1:0] m_lo, m_hi, m_val;
    logic [33:0]       e_adj;
    logic [TIME_W-1:0] l_adj;
    logic [34:0]       ne;
    logic [32:0]       gap, bdiff;
    logic [TIME_W-1:0] pl;
    logic [LOC_W-1:0]  w_loc;
    logic [TIME_W-1:0] w_svc;

    assign cnt_c  = (r_job_q.cnt > CNT_W'(MAX_WIN)) ? CNT_W'(MAX_WIN) : r_job_q.cnt;
    assign cnt_m1 = cnt_c - 3'd1;

    assign e_calc = (r_pos != '0) ? ({2'b0, r_pear} + {2'b0, r_psvc} + {2'b0, r_trv_q})
                  : (r_hs ? ({2'b0, r_vst} + {2'b0, r_trv_q}) : {2'b0, r_vst});

    assign at_end = (r_pos == r_count);
    assign nt     = at_end ? (r_he ? r_trv_q : '0) : r_trv_q;
    assign nl     = at_end ? r_vet : r_slat;
    assign need   = {1'b0, r_e} + {3'b0, r_osvc} + {3'b0, nt};
    assign l_calc = {3'b0, nl} - {3'b0, r_osvc} - {3'b0, nt};

    // Window margin; the earliest time is at most the latest, so 32 bits hold it.
    assign m_lo  = (r_e[31:0] > r_win_q.open) ? r_e[31:0] : r_win_q.open;
    assign m_hi  = (r_l < r_win_q.close) ? r_l : r_win_q.close;
    assign m_val = (m_hi > m_lo) ? (m_hi - m_lo) : '0;

    assign e_adj = (r_e > {2'b0, r_bo}) ? r_e : {2'b0, r_bo};
    assign l_adj = (r_bc < r_l) ? r_bc : r_l;

    assign ne    = {2'b0, r_chain} + {3'b0, r_svc3} + {3'b0, r_trv_q};
    assign gap   = {1'b0, r_svc3} + {1'b0, r_trv_q};
    assign bdiff = r_chain - gap;
    assign pl    = (gap > r_chain) ? '0 : bdiff[31:0];

    assign w_loc = r_job_q.loc;
    assign w_svc = r_job_q.svc;

    always_comb begin
        n_state      = r_state;
        n_m_valid    = r_m_valid;
        n_m_data     = r_m_data;
        n_count      = r_count;
        n_func       = r_func;
        n_job        = r_job;
        n_pos        = r_pos;
        n_oloc       = r_oloc;
        n_osvc       = r_osvc;
        n_cnt        = r_cnt;
        n_pear       = r_pear;
        n_psvc       = r_psvc;
        n_slat       = r_slat;
        n_lclose     = r_lclose;
        n_e          = r_e;
        n_l          = r_l;
        n_w          = r_w;
        n_first      = r_first;
        n_best       = r_best;
        n_marg       = r_marg;
        n_bo         = r_bo;
        n_bc         = r_bc;
        n_i          = r_i;
        n_dir        = r_dir;
        n_k          = r_k;
        n_left       = r_left;
        n_chain      = r_chain;
        n_prev_loc   = r_prev_loc;
        n_prev_svc   = r_prev_svc;
        n_v1         = 1'b0;
        n_v2         = 1'b0;
        n_v3         = 1'b0;
        n_idx1       = r_idx1;
        n_idx2       = r_idx2;
        n_idx3       = r_idx3;
        n_ent2       = r_ent2;
        n_ent3       = r_ent3;
        n_svc3       = r_svc3;
        n_res_status = r_res_status;
        n_res_feas   = r_res_feas;
        n_res_ch     = r_res_ch;
        n_res_e      = r_res_e;
        n_res_l      = r_res_l;

        trv_ra = '0; trv_wa = '0; trv_wd = '0; trv_we = 1'b0;
        job_ra = '0; job_wa = '0; job_wd = '0; job_we = 1'b0;
        win_ra = '0; win_wa = '0; win_wd = '0; win_we = 1'b0;
        rte_ra = '0; rte_wa = '0; rte_wd = '0; rte_we = 1'b0;

        if (r_m_valid && m_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (s_tvalid) begin
                    n_func       = s_tuser;
                    n_job        = in_job;
                    n_pos        = in_pos;
                    n_res_status = S_OK;
                    n_res_feas   = 1'b0;
                    n_res_ch     = '0;
                    n_res_e      = '0;
                    n_res_l      = '0;
                    n_state      = ST_DONE;
                    job_ra       = in_job;
                    rte_ra       = in_pos[RIDX_W-1:0] - 6'd1;
                    case (s_tuser)
                        F_TRAVEL: begin
                            trv_we = 1'b1;
                            trv_wa = {in_from, in_to};
                            trv_wd = in_travel;
                        end
                        F_JOB: begin
                            job_we = 1'b1;
                            job_wa = in_job;
                            job_wd = '{cnt: in_wcnt, svc: in_svc, loc: in_jloc};
                        end
                        F_WIN: begin
                            win_we = 1'b1;
                            win_wa = {in_job, in_slot};
                            win_wd = '{close: in_close, open: in_open};
                        end
                        F_CHECK: begin
                            if (in_pos > r_count) begin
                                n_res_status = S_BADPOS;
                            end else begin
                                n_state = ST_J1;
                            end
                        end
                        F_ADD: begin
                            if (r_count >= POS_W'(ROUTE_DEPTH)) begin
                                n_res_status = S_FULL;
                            end else if (in_pos > r_count) begin
                                n_res_status = S_BADPOS;
                            end else begin
                                n_state = ST_J1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            // Own job record and predecessor entry are in; fetch the next layer.
            ST_J1: begin
                if (r_job_q.cnt == '0) begin
                    n_res_status = S_INFEAS;
                    n_state      = ST_DONE;
                end else begin
                    n_cnt   = cnt_c;
                    n_oloc  = r_job_q.loc;
                    n_osvc  = r_job_q.svc;
                    n_pear  = r_rte_q.ear;
                    job_ra  = r_rte_q.job;
                    rte_ra  = r_pos[RIDX_W-1:0];
                    win_ra  = {r_job, cnt_m1[SLOT_W-1:0]};
                    n_state = ST_J2;
                end
            end
            ST_J2: begin
                n_psvc   = r_job_q.svc;
                n_slat   = r_rte_q.lat;
                n_lclose = r_win_q.close;
                job_ra   = r_rte_q.job;
                trv_ra   = (r_pos != '0) ? {r_job_q.loc, r_oloc} : {r_sdl, r_oloc};
                n_state  = ST_J3;
            end
            ST_J3: begin
                n_e     = e_calc;
                trv_ra  = {r_oloc, at_end ? r_edl : r_job_q.loc};
                n_state = ST_J4;
            end
            ST_J4: begin
                if (({2'b0, r_lclose} < r_e) || (need > {3'b0, nl})) begin
                    n_res_status = S_INFEAS;
                    n_state      = ST_DONE;
                end else begin
                    n_l     = l_calc[TIME_W-1:0];
                    n_w     = '0;
                    win_ra  = {r_job, 2'd0};
                    n_state = ST_SCAN;
                end
            end
            // First window whose close is not before the earliest time decides.
            ST_SCAN: begin
                if ({2'b0, r_win_q.close} >= r_e) begin
                    if (r_win_q.open <= r_l) begin
                        if (r_func == F_CHECK) begin
                            n_res_feas = 1'b1;
                            n_state    = ST_DONE;
                        end else begin
                            n_first = r_w;
                            win_ra  = {r_job, r_w};
                            n_state = ST_MARG;
                        end
                    end else begin
                        n_res_status = S_INFEAS;
                        n_state      = ST_DONE;
                    end
                end else if (({1'b0, r_w} + 3'd1) >= r_cnt) begin
                    n_res_status = S_INFEAS;
                    n_state      = ST_DONE;
                end else begin
                    n_w    = r_w + 2'd1;
                    win_ra = {r_job, r_w + 2'd1};
                end
            end
            ST_MARG: begin
                if (r_win_q.open > r_l) begin
                    n_state = ST_ADJ;
                end else begin
                    if ((r_w == r_first) || (m_val > r_marg)) begin
                        n_best = r_w;
                        n_marg = m_val;
                        n_bo   = r_win_q.open;
                        n_bc   = r_win_q.close;
                    end
                    if (({1'b0, r_w} + 3'd1) >= r_cnt) begin
                        n_state = ST_ADJ;
                    end else begin
                        n_w    = r_w + 2'd1;
                        win_ra = {r_job, r_w + 2'd1};
                    end
                end
            end
            ST_ADJ: begin
                n_e = e_adj;
                n_l = l_adj;
                if (r_count > r_pos) begin
                    n_i     = r_count[RIDX_W-1:0];
                    rte_ra  = r_count[RIDX_W-1:0] - 6'd1;
                    n_state = ST_SHIFT;
                end else begin
                    n_state = ST_INS;
                end
            end
            // Move entries up by one, from the tail down to the insertion rank.
            ST_SHIFT: begin
                rte_we = 1'b1;
                rte_wa = r_i;
                rte_wd = r_rte_q;
                if ((r_i - 6'd1) == r_pos[RIDX_W-1:0]) begin
                    n_state = ST_INS;
                end else begin
                    n_i    = r_i - 6'd1;
                    rte_ra = r_i - 6'd2;
                end
            end
            ST_INS: begin
                rte_we     = 1'b1;
                rte_wa     = r_pos[RIDX_W-1:0];
                rte_wd     = '{win: r_best, lat: r_l, ear: r_e[TIME_W-1:0], job: r_job};
                n_count    = r_count + 7'd1;
                n_dir      = 1'b0;
                n_k        = r_pos[RIDX_W-1:0] + 6'd1;
                n_left     = r_count - r_pos;
                n_chain    = {1'b0, r_e[TIME_W-1:0]};
                n_prev_loc = r_oloc;
                n_prev_svc = r_osvc;
                n_state    = ST_WALK;
            end
            // Three-stage walk: route entry, its job record, travel time, then update.
            ST_WALK: begin
                if (r_left != '0) begin
                    rte_ra = r_k;
                    n_v1   = 1'b1;
                    n_idx1 = r_k;
                    n_k    = r_dir ? (r_k - 6'd1) : (r_k + 6'd1);
                    n_left = r_left - 7'd1;
                end
                if (r_v1) begin
                    n_v2   = 1'b1;
                    n_ent2 = r_rte_q;
                    n_idx2 = r_idx1;
                    job_ra = r_rte_q.job;
                end
                if (r_v2) begin
                    n_v3       = 1'b1;
                    n_ent3     = r_ent2;
                    n_idx3     = r_idx2;
                    trv_ra     = r_dir ? {w_loc, r_prev_loc} : {r_prev_loc, w_loc};
                    n_svc3     = r_dir ? w_svc : r_prev_svc;
                    n_prev_loc = w_loc;
                    n_prev_svc = w_svc;
                end
                if (r_v3 && !r_dir && (ne > {3'b0, r_ent3.ear})) begin
                    rte_we     = 1'b1;
                    rte_wa     = r_idx3;
                    rte_wd     = r_ent3;
                    rte_wd.ear = (ne >= 35'(TIME_SAT)) ? '1 : ne[TIME_W-1:0];
                    n_chain    = (ne >= 35'(TIME_SAT)) ? TIME_SAT : ne[32:0];
                end
                if (r_v3 && r_dir && (r_ent3.lat > pl)) begin
                    rte_we     = 1'b1;
                    rte_wa     = r_idx3;
                    rte_wd     = r_ent3;
                    rte_wd.lat = pl;
                    n_chain    = {1'b0, pl};
                end
                // Walks stop when a stored time meets the bound or entries run out.
                if ((r_v3 && !r_dir && (ne <= {3'b0, r_ent3.ear}))
                    || (r_v3 && r_dir && (r_ent3.lat <= pl))
                    || ((r_left == '0) && !r_v1 && !r_v2 && !r_v3)) begin
                    n_v1 = 1'b0;
                    n_v2 = 1'b0;
                    n_v3 = 1'b0;
                    if (!r_dir) begin
                        n_dir      = 1'b1;
                        n_k        = r_pos[RIDX_W-1:0] - 6'd1;
                        n_left     = r_pos;
                        n_chain    = {1'b0, r_l};
                        n_prev_loc = r_oloc;
                        n_prev_svc = r_osvc;
                    end else begin
                        n_res_status = S_OK;
                        n_res_feas   = 1'b1;
                        n_res_ch     = r_best;
                        n_res_e      = r_e[TIME_W-1:0];
                        n_res_l      = r_l;
                        n_state      = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (!r_m_valid || m_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = {4'b0, r_res_l, r_res_e, r_res_ch, r_count,
                                 r_res_feas, r_res_status};
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_m_valid <= 1'b0;
            r_count   <= '0;
            r_dir     <= 1'b0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
            r_count   <= n_count;
            r_dir     <= n_dir;
            r_v1      <= n_v1;
            r_v2      <= n_v2;
            r_v3      <= n_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_data     <= n_m_data;
        r_func       <= n_func;
        r_job        <= n_job;
        r_pos        <= n_pos;
        r_oloc       <= n_oloc;
        r_osvc       <= n_osvc;
        r_cnt        <= n_cnt;
        r_pear       <= n_pear;
        r_psvc       <= n_psvc;
        r_slat       <= n_slat;
        r_lclose     <= n_lclose;
        r_e          <= n_e;
        r_l          <= n_l;
        r_w          <= n_w;
        r_first      <= n_first;
        r_best       <= n_best;
        r_marg       <= n_marg;
        r_bo         <= n_bo;
        r_bc         <= n_bc;
        r_i          <= n_i;
        r_k          <= n_k;
        r_left       <= n_left;
        r_chain      <= n_chain;
        r_prev_loc   <= n_prev_loc;
        r_prev_svc   <= n_prev_svc;
        r_idx1       <= n_idx1;
        r_idx2       <= n_idx2;
        r_idx3       <= n_idx3;
        r_ent2       <= n_ent2;
        r_ent3       <= n_ent3;
        r_svc3       <= n_svc3;
        r_res_status <= n_res_status;
        r_res_feas   <= n_res_feas;
        r_res_ch     <= n_res_ch;
        r_res_e      <= n_res_e;
        r_res_l      <= n_res_l;
    end

    assign s_tready = (r_state == ST_IDLE);
    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_data;

endmodule

@@ test/time_window_route_insertion_test.sv @@
// Self-checking testbench for the time window route insertion block.
module time_window_route_insertion_test;
    import twri_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam logic [63:0] TIME_MAX = 64'h0000_0000_FFFF_FFFF;

    typedef struct packed {
        logic [2:0]  func;
        logic [5:0]  job;
        logic [6:0]  pos;
        logic [5:0]  from_loc;
        logic [5:0]  to_loc;
        logic [31:0] trav;
        logic [5:0]  jloc;
        logic [31:0] svc;
        logic [2:0]  wcnt;
        logic [1:0]  slot;
        logic [31:0] wopen;
        logic [31:0] wclose;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  status;
        logic        feas;
        logic [6:0]  len;
        logic [1:0]  win;
        logic [31:0] ear;
        logic [31:0] lat;
    } t_answer;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [TIME_W-1:0]    i_cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [167:0]         s_tdata = '0;
    logic [2:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [79:0]          m_tdata;

    time_window_route_insertion dut (.*);

    always #2 i_clk = ~i_clk;

    // Shadow copy of the block's tables, route and registers.
    logic [63:0] veh_start, veh_end, sd_on, sd_loc, ed_on, ed_loc;
    logic [63:0] trav_tab [4096];
    logic [63:0] loc_tab [64];
    logic [63:0] svc_tab [64];
    logic [63:0] cnt_tab [64];
    logic [63:0] open_tab [256];
    logic [63:0] close_tab [256];
    logic [63:0] r_job [65];
    logic [63:0] r_ear [65];
    logic [63:0] r_lat [65];
    logic [63:0] r_win [65];
    logic [63:0] r_count;

    t_answer pending_answers [$];
    int      errors = 0;
    int      idle_cycles = 0;
    bit      hold_request = 0;

    function automatic logic [63:0] sadd(logic [63:0] a, logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        return (s < a) ? '1 : s;
    endfunction

    function automatic logic [63:0] tclamp(logic [63:0] v);
        return (v > TIME_MAX) ? TIME_MAX : v;
    endfunction

    function automatic logic [63:0] trav_of(logic [63:0] f, logic [63:0] t);
        return trav_tab[f[5:0] * 64 + t[5:0]];
    endfunction

    function automatic logic [63:0] used_windows(logic [63:0] j);
        return (cnt_tab[j] > MAX_WIN) ? MAX_WIN : cnt_tab[j];
    endfunction

    // Jobs and depots only sit on eight locations spread over the whole index range,
    // so the travel entries that are ever read are all loaded up front.
    function automatic logic [5:0] loc_of(int k);
        return 6'(k * 9);
    endfunction

    function automatic logic [5:0] pick_loc();
        return loc_of($urandom_range(0, 7));
    endfunction

    function automatic bit job_fits(input logic [63:0] j, input logic [63:0] rank,
                                    output logic [63:0] e, output logic [63:0] l,
                                    output logic [63:0] first);
        logic [63:0] cnt, base, nl, nt, need, pj;
        e = 0; l = 0; first = 0;
        cnt = used_windows(j);
        if (cnt == 0) return 0;
        base = j * MAX_WIN;
        if (rank > 0) begin
            pj = r_job[rank - 1];
            e = sadd(sadd(r_ear[rank - 1], svc_tab[pj]), trav_of(loc_tab[pj], loc_tab[j]));
        end else if (sd_on != 0) begin
            e = sadd(veh_start, trav_of(sd_loc, loc_tab[j]));
        end else begin
            e = veh_start;
        end
        if (close_tab[base + cnt - 1] < e) return 0;
        if (rank == r_count) begin
            nl = veh_end;
            nt = (ed_on != 0) ? trav_of(loc_tab[j], ed_loc) : 0;
        end else begin
            nl = r_lat[rank];
            nt = trav_of(loc_tab[j], loc_tab[r_job[rank]]);
        end
        need = sadd(sadd(e, svc_tab[j]), nt);
        if (need > nl) return 0;
        l = nl - svc_tab[j] - nt;
        for (int w = 0; w < cnt; w++) begin
            if (e <= close_tab[base + w]) begin
                first = 64'(w);
                return open_tab[base + w] <= l;
            end
        end
        return 0;
    endfunction

    function automatic t_answer predict_route_result(t_cmd c);
        t_answer     a;
        logic [63:0] e, l, first, base, cnt, best, best_m, o, cl, lo, hi, m;
        logic [63:0] prev, ne, nl, gap, pl, pj, p;
        a = '0;
        p = c.pos;
        case (c.func)
            F_TRAVEL: trav_tab[c.from_loc * 64 + c.to_loc] = c.trav;
            F_JOB: begin
                loc_tab[c.job] = c.jloc;
                svc_tab[c.job] = c.svc;
                cnt_tab[c.job] = c.wcnt;
            end
            F_WIN: begin
                open_tab[c.job * MAX_WIN + c.slot] = c.wopen;
                close_tab[c.job * MAX_WIN + c.slot] = c.wclose;
            end
            F_CHECK: begin
                if (p > r_count) a.status = S_BADPOS;
                else if (job_fits(c.job, p, e, l, first)) a.feas = 1;
                else a.status = S_INFEAS;
            end
            F_ADD: begin
                if (r_count >= ROUTE_DEPTH) a.status = S_FULL;
                else if (p > r_count) a.status = S_BADPOS;
                else if (!job_fits(c.job, p, e, l, first)) a.status = S_INFEAS;
                else begin
                    base = c.job * MAX_WIN;
                    cnt = used_windows(c.job);
                    best = first;
                    best_m = 0;
                    for (logic [63:0] w = first; w < cnt; w++) begin
                        o = open_tab[base + w];
                        cl = close_tab[base + w];
                        if (o > l) break;
                        lo = (e > o) ? e : o;
                        hi = (l < cl) ? l : cl;
                        m = (hi > lo) ? hi - lo : 0;
                        if (m > best_m) begin
                            best = w;
                            best_m = m;
                        end
                    end
                    if (open_tab[base + best] > e) e = open_tab[base + best];
                    if (close_tab[base + best] < l) l = close_tab[base + best];
                    e = tclamp(e);
                    l = tclamp(l);
                    for (logic [63:0] i = r_count; i > p; i--) begin
                        r_job[i] = r_job[i - 1];
                        r_ear[i] = r_ear[i - 1];
                        r_lat[i] = r_lat[i - 1];
                        r_win[i] = r_win[i - 1];
                    end
                    r_job[p] = c.job;
                    r_ear[p] = e;
                    r_lat[p] = l;
                    r_win[p] = best;
                    r_count++;
                    // Earliest times ripple forward until one no longer moves.
                    prev = e;
                    for (logic [63:0] i = p + 1; i < r_count; i++) begin
                        pj = r_job[i - 1];
                        ne = sadd(sadd(prev, svc_tab[pj]), trav_of(loc_tab[pj], loc_tab[r_job[i]]));
                        if (ne <= r_ear[i]) break;
                        r_ear[i] = tclamp(ne);
                        prev = ne;
                    end
                    // Latest times ripple backward the same way.
                    nl = l;
                    for (logic [63:0] i = p; i > 0; i--) begin
                        pj = r_job[i - 1];
                        gap = sadd(svc_tab[pj], trav_of(loc_tab[pj], loc_tab[r_job[i]]));
                        pl = (gap > nl) ? 0 : nl - gap;
                        if (r_lat[i - 1] <= pl) break;
                        r_lat[i - 1] = pl;
                        nl = pl;
                    end
                    a.feas = 1;
                    a.win = best[1:0];
                    a.ear = e[31:0];
                    a.lat = l[31:0];
                end
            end
            default: ;
        endcase
        a.len = r_count[6:0];
        return a;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(30, 150);
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        errors++;
    endtask

    // Valid stays high from one word to the next when there is no gap between them.
    task automatic send_cmd(t_cmd c);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c.func;
        s_tdata  <= {4'b0, c.wclose, c.wopen, c.slot, c.wcnt, c.svc, c.jloc, c.trav,
                     c.to_loc, c.from_loc, c.pos, c.job};
        // Ready only moves at a rising edge, so its value at the falling edge holds.
        do @(negedge i_clk); while (!s_tready);
        @(posedge i_clk);
        pending_answers.push_back(predict_route_result(c));
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v[31:0];
        case (idx)
            CFG_VSTART: veh_start = v[31:0];
            CFG_VEND:   veh_end = v[31:0];
            CFG_HAS_SD: sd_on = v[0];
            CFG_SD_LOC: sd_loc = v[5:0];
            CFG_HAS_ED: ed_on = v[0];
            CFG_ED_LOC: ed_loc = v[5:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic set_vehicle(logic [63:0] vs, logic [63:0] ve, bit sdo, logic [5:0] sdl,
                               bit edo, logic [5:0] edl);
        wait_drained();
        write_reg(CFG_VSTART, vs);
        write_reg(CFG_VEND, ve);
        write_reg(CFG_HAS_SD, sdo);
        write_reg(CFG_SD_LOC, sdl);
        write_reg(CFG_HAS_ED, edo);
        write_reg(CFG_ED_LOC, edl);
    endtask

    function automatic t_cmd noise_cmd();
        t_cmd         c;
        logic [191:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        c = raw[$bits(t_cmd)-1:0];
        return c;
    endfunction

    function automatic t_cmd window_cmd(logic [5:0] j, logic [1:0] s);
        t_cmd c;
        c = noise_cmd();
        c.func = F_WIN;
        c.job = j;
        c.slot = s;
        c.wopen = s * 3000 + $urandom_range(0, 2500);
        c.wclose = c.wopen + $urandom_range(0, 20000);
        return c;
    endfunction

    function automatic t_cmd job_cmd(logic [5:0] j);
        t_cmd c;
        c = noise_cmd();
        c.func = F_JOB;
        c.job = j;
        c.jloc = pick_loc();
        c.svc = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 40);
        c.wcnt = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(1, 4))
                                             : 3'($urandom_range(0, 7));
        return c;
    endfunction

    function automatic t_cmd route_cmd(logic [2:0] f);
        t_cmd c;
        int   r;
        c = noise_cmd();
        c.func = f;
        r = $urandom_range(0, 9);
        if (r < 8) c.pos = 7'($urandom_range(0, r_count[6:0]));
        else if (r < 9) c.pos = r_count[6:0];
        return c;
    endfunction

    task automatic test_load_tables();
        t_cmd c;
        for (int f = 0; f < 8; f++) begin
            for (int t = 0; t < 8; t++) begin
                c = noise_cmd();
                c.func = F_TRAVEL;
                c.from_loc = loc_of(f);
                c.to_loc = loc_of(t);
                c.trav = $urandom_range(0, 60);
                send_cmd(c);
            end
        end
        for (int j = 0; j < 64; j++) begin
            send_cmd(job_cmd(6'(j)));
            for (int s = 0; s < MAX_WIN; s++) send_cmd(window_cmd(6'(j), 2'(s)));
        end
    endtask

    task automatic test_directed();
        t_cmd c;
        for (int f = 5; f < 8; f++) begin
            c = noise_cmd();
            c.func = 3'(f);
            send_cmd(c);
        end
        // Position past the route end on both check and add.
        c = route_cmd(F_CHECK); c.pos = 7'h7F; send_cmd(c);
        c = route_cmd(F_ADD);   c.pos = 7'h7F; send_cmd(c);
        // A job with no windows can never fit.
        c = job_cmd(5); c.wcnt = 0; send_cmd(c);
        c = route_cmd(F_ADD); c.job = 5; c.pos = 0; send_cmd(c);
        // More windows than the table holds are cut to the table size.
        c = job_cmd(6); c.wcnt = 7; c.svc = 0; send_cmd(c);
        c = route_cmd(F_ADD); c.job = 6; c.pos = 0; send_cmd(c);
        // Full-scale service and window close exercise the saturating sums.
        c = job_cmd(7); c.wcnt = 1; c.svc = '1; send_cmd(c);
        c = window_cmd(7, 0); c.wopen = 0; c.wclose = '1; send_cmd(c);
        c = route_cmd(F_CHECK); c.job = 7; c.pos = 0; send_cmd(c);
        c = route_cmd(F_ADD);   c.job = 7; c.pos = r_count[6:0]; send_cmd(c);
        // An inverted window.
        c = window_cmd(8, 0); c.wopen = 9000; c.wclose = 100; send_cmd(c);
        c = route_cmd(F_CHECK); c.job = 8; c.pos = 0; send_cmd(c);
        // Largest travel time, then put a small value back.
        c = noise_cmd(); c.func = F_TRAVEL; c.from_loc = 63; c.to_loc = 0; c.trav = '1;
        send_cmd(c);
        c = route_cmd(F_CHECK); send_cmd(c);
        c.func = F_TRAVEL; c.from_loc = 63; c.to_loc = 0; c.trav = 0; send_cmd(c);
        c = route_cmd(F_ADD); c.job = 6; c.pos = 0; send_cmd(c);
        c = job_cmd(7); send_cmd(c);
        c = job_cmd(5); send_cmd(c);
    endtask

    task automatic test_random(int n);
        t_cmd c;
        int   r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                c = noise_cmd();
                c.func = F_TRAVEL;
                if ($urandom_range(0, 3) != 0) begin
                    c.from_loc = pick_loc();
                    c.to_loc = pick_loc();
                end
                if ($urandom_range(0, 9) != 0) c.trav = $urandom_range(0, 60);
            end else if (r < 14) begin
                c = job_cmd(6'($urandom_range(0, 63)));
            end else if (r < 24) begin
                c = window_cmd(6'($urandom_range(0, 63)), 2'($urandom_range(0, 3)));
                if ($urandom_range(0, 9) == 0) begin
                    c.wopen = $urandom;
                    c.wclose = $urandom;
                end
            end else if (r < 62) begin
                c = route_cmd(F_CHECK);
            end else if (r < 96) begin
                c = route_cmd(F_ADD);
            end else begin
                c = noise_cmd();
                c.func = 3'($urandom_range(5, 7));
            end
            send_cmd(c);
        end
    endtask

    // Words keep coming until the result side has finished its long hold.
    task automatic test_backpressure();
        hold_request = 1;
        while (hold_request) test_random(1);
        test_random(20);
    endtask

    task automatic test_fill_route();
        t_cmd c;
        c = noise_cmd(); c.func = F_TRAVEL; c.from_loc = 63; c.to_loc = 63; c.trav = 0;
        send_cmd(c);
        c = job_cmd(63); c.jloc = 63; c.svc = 0; c.wcnt = 1; send_cmd(c);
        c = window_cmd(63, 0); c.wopen = 0; c.wclose = '1; send_cmd(c);
        // An earlier tail may leave no room in time, so the attempts are bounded.
        for (int k = 0; (k < 2 * ROUTE_DEPTH) && (r_count < ROUTE_DEPTH); k++) begin
            c = route_cmd(F_ADD);
            c.job = 63;
            c.pos = r_count[6:0];
            send_cmd(c);
        end
        test_random(30);
    endtask

    // Result side: random ready gaps, plus one long hold on request.
    initial begin
        int n;
        forever begin
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_request = 0;
            end
            n = $urandom_range(1, 40);
            m_tready <= 1'b1;
            repeat (n) @(posedge i_clk);
            n = pick_gap();
            if (n > 0) begin
                m_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_answer got, want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = {m_tdata[1:0], m_tdata[2], m_tdata[9:3], m_tdata[11:10],
                   m_tdata[43:12], m_tdata[75:44]};
            if (pending_answers.size() == 0) begin
                report_mismatch("unexpected word", got.len, 0);
            end else begin
                want = pending_answers.pop_front();
                if (got.status !== want.status) report_mismatch("status", got.status, want.status);
                if (got.feas !== want.feas) report_mismatch("feasible", got.feas, want.feas);
                if (got.len !== want.len) report_mismatch("route_length", got.len, want.len);
                if (got.win !== want.win) report_mismatch("chosen_window", got.win, want.win);
                if (got.ear !== want.ear) report_mismatch("start_earliest", got.ear, want.ear);
                if (got.lat !== want.lat) report_mismatch("start_latest", got.lat, want.lat);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("time_window_route_insertion_test: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        veh_start = 0; veh_end = TIME_MAX; sd_on = 0; sd_loc = 0; ed_on = 0; ed_loc = 0;
        r_count = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_load_tables();
        test_directed();
        test_random(280);
        set_vehicle(0, TIME_MAX, 1, 63, 1, 0);
        test_random(230);
        test_backpressure();
        set_vehicle(1000, 30000, 1, 0, 1, 63);
        test_random(200);
        set_vehicle(TIME_MAX, TIME_MAX, 0, pick_loc(), 1, pick_loc());
        test_random(50);
        set_vehicle(0, 0, 1, pick_loc(), 0, pick_loc());
        test_random(50);
        set_vehicle(0, TIME_MAX, 0, 0, 0, 0);
        test_fill_route();
        wait_drained();
        if (errors == 0)
            $display("time_window_route_insertion_test: clean");
        else
            $display("time_window_route_insertion_test: errors");
        $finish;
    end

endmodule
